@@ hw/rtl/caseu_pkg.sv @@
package caseu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned NumRegs = 16;
  localparam int unsigned RegAddrW = 4;

  localparam logic [RegAddrW-1:0] REG_LR = 4'd14;
  localparam logic [RegAddrW-1:0] REG_PC = 4'd15;

  typedef enum logic [1:0] {
    FUNC_DP  = 2'd0,
    FUNC_MUL = 2'd1,
    FUNC_BR  = 2'd2,
    FUNC_LDR = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } opcode_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_e;

  // flags are packed N, Z, C, V from msb to lsb
  typedef struct packed {
    logic [1:0]          func;
    logic [3:0]          cond;
    logic [3:0]          opcode;
    logic                imm_operand;
    logic                set_flags;
    logic [RegAddrW-1:0] reg_n;
    logic [RegAddrW-1:0] reg_d;
    logic [11:0]         operand2;
    logic                accumulate_or_link;
    logic [23:0]         branch_offset;
    logic [DataW-1:0]    load_value;
  } req_t;

  typedef struct packed {
    logic                executed;
    logic                wrote_register;
    logic [RegAddrW-1:0] dest_reg;
    logic [DataW-1:0]    result;
    logic                flag_n;
    logic                flag_z;
    logic                flag_c;
    logic                flag_v;
    logic                flush;
  } rsp_t;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [DataW-1:0]    data;
    logic                link_en;
    logic [DataW-1:0]    link_data;
  } wr_t;

  function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
    logic n;
    logic z;
    logic cf;
    logic v;
    logic pass;
    n  = f[3];
    z  = f[2];
    cf = f[1];
    v  = f[0];
    case (c)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = cf;
      COND_CC: pass = !cf;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = cf && !z;
      COND_LS: pass = !cf || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      default: pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

@@ hw/rtl/caseu_in_if.sv @@
interface caseu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  cond;
  logic [3:0]  opcode;
  logic        imm_operand;
  logic        set_flags;
  logic [3:0]  reg_n;
  logic [3:0]  reg_d;
  logic [11:0] operand2;
  logic        accumulate_or_link;
  logic [23:0] branch_offset;
  logic [31:0] load_value;

  modport source (
    output valid, func, cond, opcode, imm_operand, set_flags, reg_n, reg_d, operand2,
           accumulate_or_link, branch_offset, load_value,
    input  ready
  );

  modport sink (
    input  valid, func, cond, opcode, imm_operand, set_flags, reg_n, reg_d, operand2,
           accumulate_or_link, branch_offset, load_value,
    output ready
  );
endinterface

@@ hw/rtl/caseu_out_if.sv @@
interface caseu_out_if;
  logic        valid;
  logic        ready;
  logic        executed;
  logic        wrote_register;
  logic [3:0]  dest_reg;
  logic [31:0] result;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;
  logic        flush;

  modport source (
    output valid, executed, wrote_register, dest_reg, result, flag_n, flag_z, flag_c,
           flag_v, flush,
    input  ready
  );

  modport sink (
    input  valid, executed, wrote_register, dest_reg, result, flag_n, flag_z, flag_c,
           flag_v, flush,
    output ready
  );
endinterface

@@ hw/rtl/caseu_shifter.sv @@
module caseu_shifter (
  input  logic [caseu_pkg::DataW-1:0] value_i,
  input  logic [1:0]                  type_i,
  input  logic [7:0]                  amount_i,
  input  logic                        carry_i,
  output logic [caseu_pkg::DataW-1:0] value_o,
  output logic                        carry_o
);

  logic [32:0]        lsl_w;
  logic [32:0]        lsr_w;
  logic signed [32:0] asr_w;
  logic [63:0]        ror_w;
  logic               big;
  logic               eq32;

  always_comb begin
    lsl_w = {1'b0, value_i} << amount_i[4:0];
    lsr_w = {value_i, 1'b0} >> amount_i[4:0];
    asr_w = $signed({value_i, 1'b0}) >>> amount_i[4:0];
    ror_w = {value_i, value_i} >> amount_i[4:0];
    big   = (amount_i[7:5] != 3'd0);
    eq32  = (amount_i == 8'd32);

    value_o = value_i;
    carry_o = carry_i;
    if (amount_i != 8'd0) begin
      case (type_i)
        caseu_pkg::SH_LSL: begin
          if (!big) begin
            value_o = lsl_w[31:0];
            carry_o = lsl_w[32];
          end else begin
            value_o = '0;
            carry_o = eq32 & value_i[0];
          end
        end
        caseu_pkg::SH_LSR: begin
          if (!big) begin
            value_o = lsr_w[32:1];
            carry_o = lsr_w[0];
          end else begin
            value_o = '0;
            carry_o = eq32 & value_i[31];
          end
        end
        caseu_pkg::SH_ASR: begin
          if (!big) begin
            value_o = asr_w[32:1];
            carry_o = asr_w[0];
          end else begin
            value_o = {32{value_i[31]}};
            carry_o = value_i[31];
          end
        end
        default: begin
          // rotate by a multiple of 32 keeps the value, carry is the msb
          if (amount_i[4:0] == 5'd0) begin
            value_o = value_i;
            carry_o = value_i[31];
          end else begin
            value_o = ror_w[31:0];
            carry_o = ror_w[31];
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/caseu_regfile.sv @@
module caseu_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [caseu_pkg::RegAddrW-1:0] rn_addr_i,
  input  logic [caseu_pkg::RegAddrW-1:0] rm_addr_i,
  input  logic [caseu_pkg::RegAddrW-1:0] rs_addr_i,
  output logic [caseu_pkg::DataW-1:0]    rn_data_o,
  output logic [caseu_pkg::DataW-1:0]    rm_data_o,
  output logic [caseu_pkg::DataW-1:0]    rs_data_o,
  output logic [caseu_pkg::DataW-1:0]    pc_data_o,
  input  caseu_pkg::wr_t                 wr_i
);

  logic [caseu_pkg::DataW-1:0] rf_q [caseu_pkg::NumRegs];

  assign rn_data_o = rf_q[rn_addr_i];
  assign rm_data_o = rf_q[rm_addr_i];
  assign rs_data_o = rf_q[rs_addr_i];
  assign pc_data_o = rf_q[caseu_pkg::REG_PC];

  // the link write always goes to r14; the regfile does not tie it to a write of r15 on the main port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < caseu_pkg::NumRegs; i++) begin
        rf_q[i] <= '0;
      end
    end else begin
      if (wr_i.en) begin
        rf_q[wr_i.addr] <= wr_i.data;
      end
      if (wr_i.link_en) begin
        rf_q[caseu_pkg::REG_LR] <= wr_i.link_data;
      end
    end
  end

endmodule

@@ hw/rtl/caseu_exec.sv @@
module caseu_exec (
  input  caseu_pkg::req_t              req_i,
  input  logic [3:0]                   flags_i,
  input  logic [caseu_pkg::DataW-1:0]  rn_data_i,
  input  logic [caseu_pkg::DataW-1:0]  rm_data_i,
  input  logic [caseu_pkg::DataW-1:0]  rs_data_i,
  input  logic [caseu_pkg::DataW-1:0]  pc_data_i,
  output caseu_pkg::rsp_t              rsp_o,
  output caseu_pkg::wr_t               wr_o,
  output logic [3:0]                   flags_o
);

  logic [caseu_pkg::DataW-1:0] sh_in;
  logic [1:0]                  sh_type;
  logic [7:0]                  sh_amt;
  logic [caseu_pkg::DataW-1:0] b;
  logic                        sh_carry;
  logic [caseu_pkg::DataW:0]   sub_ab;
  logic [caseu_pkg::DataW:0]   sub_ba;
  logic [caseu_pkg::DataW:0]   add_ab;
  logic [caseu_pkg::DataW-1:0] prod;
  logic [caseu_pkg::DataW-1:0] br_off;
  logic                        pass;
  logic                        dp_valid;
  logic                        dp_write;
  logic                        carry;
  logic [caseu_pkg::DataW-1:0] res;
  logic                        executed;

  always_comb begin
    if (req_i.imm_operand) begin
      sh_in   = {24'd0, req_i.operand2[7:0]};
      sh_type = caseu_pkg::SH_ROR;
      sh_amt  = {3'd0, req_i.operand2[11:8], 1'b0};
    end else begin
      sh_in   = rm_data_i;
      sh_type = req_i.operand2[6:5];
      sh_amt  = req_i.operand2[4] ? rs_data_i[7:0] : {3'd0, req_i.operand2[11:7]};
    end
  end

  caseu_shifter u_shifter (
    .value_i  (sh_in),
    .type_i   (sh_type),
    .amount_i (sh_amt),
    .carry_i  (flags_i[1]),
    .value_o  (b),
    .carry_o  (sh_carry)
  );

  assign sub_ab = {1'b0, rn_data_i} - {1'b0, b};
  assign sub_ba = {1'b0, b} - {1'b0, rn_data_i};
  assign add_ab = {1'b0, rn_data_i} + {1'b0, b};
  assign prod   = rm_data_i * rs_data_i;
  assign br_off = {{6{req_i.branch_offset[23]}}, req_i.branch_offset, 2'b00};
  assign pass   = caseu_pkg::cond_pass(req_i.cond, flags_i);

  always_comb begin
    dp_valid = 1'b1;
    dp_write = 1'b1;
    carry    = sh_carry;
    res      = '0;
    case (req_i.opcode)
      caseu_pkg::OP_AND: res = rn_data_i & b;
      caseu_pkg::OP_EOR: res = rn_data_i ^ b;
      caseu_pkg::OP_SUB: begin
        res   = sub_ab[31:0];
        carry = ~sub_ab[32];
      end
      caseu_pkg::OP_RSB: begin
        res   = sub_ba[31:0];
        carry = ~sub_ba[32];
      end
      caseu_pkg::OP_ADD: begin
        res   = add_ab[31:0];
        carry = add_ab[32];
      end
      caseu_pkg::OP_TST: begin
        res      = rn_data_i & b;
        dp_write = 1'b0;
      end
      caseu_pkg::OP_TEQ: begin
        res      = rn_data_i ^ b;
        dp_write = 1'b0;
      end
      caseu_pkg::OP_CMP: begin
        res      = sub_ab[31:0];
        carry    = ~sub_ab[32];
        dp_write = 1'b0;
      end
      caseu_pkg::OP_ORR: res = rn_data_i | b;
      caseu_pkg::OP_MOV: res = b;
      default: begin
        dp_valid = 1'b0;
        dp_write = 1'b0;
      end
    endcase

    wr_o      = '0;
    flags_o   = flags_i;
    executed  = 1'b0;
    rsp_o     = '0;

    if (pass) begin
      case (req_i.func)
        caseu_pkg::FUNC_DP: begin
          if (dp_valid) begin
            executed    = 1'b1;
            rsp_o.result = res;
            wr_o.en     = dp_write;
            wr_o.addr   = req_i.reg_d;
            wr_o.data   = res;
            if (req_i.set_flags) begin
              flags_o = {res[31], res == '0, carry, flags_i[0]};
            end
          end
        end
        caseu_pkg::FUNC_MUL: begin
          executed     = 1'b1;
          rsp_o.result = prod + (req_i.accumulate_or_link ? rn_data_i : '0);
          wr_o.en      = 1'b1;
          wr_o.addr    = req_i.reg_d;
          wr_o.data    = rsp_o.result;
          if (req_i.set_flags) begin
            flags_o = {rsp_o.result[31], rsp_o.result == '0, flags_i[1:0]};
          end
        end
        caseu_pkg::FUNC_BR: begin
          executed       = 1'b1;
          rsp_o.result   = pc_data_i + br_off;
          wr_o.en        = 1'b1;
          wr_o.addr      = caseu_pkg::REG_PC;
          wr_o.data      = rsp_o.result;
          wr_o.link_en   = req_i.accumulate_or_link;
          wr_o.link_data = pc_data_i - 32'd4;
        end
        default: begin
          executed     = 1'b1;
          rsp_o.result = req_i.load_value;
          wr_o.en      = 1'b1;
          wr_o.addr    = req_i.reg_d;
          wr_o.data    = req_i.load_value;
        end
      endcase
    end

    rsp_o.executed       = executed;
    rsp_o.wrote_register = wr_o.en;
    rsp_o.dest_reg       = wr_o.en ? wr_o.addr : '0;
    rsp_o.flag_n         = flags_o[3];
    rsp_o.flag_z         = flags_o[2];
    rsp_o.flag_c         = flags_o[1];
    rsp_o.flag_v         = flags_o[0];
    rsp_o.flush          = wr_o.en && (wr_o.addr == caseu_pkg::REG_PC);
  end

endmodule

@@ hw/rtl/cond_alu_shift_mult_branch_execute_unit.sv @@
// Channel  Dir  Handshake         Payload
// exe_i    in   valid / ready     one decoded instruction (func, cond, operands)
// res_o    out  valid / ready     executed, write info, result, NZCV, flush
//
// Pipeline: an item is registered on accept, executed once the result register
// can take it, and its result registered at the end of that cycle; one item per
// cycle sustained while res_o is ready. The execute cycle covers the read ports,
// shifter, ALU or 32x32 multiplier.
// Reset: registers r0..r15 and the flags clear to zero.
// Stalls: a result held at res_o stalls the item in the input register; exe_i
// stops taking items only while both registers are full and the result waits.
module cond_alu_shift_mult_branch_execute_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  caseu_in_if.sink          exe_i,
  caseu_out_if.source       res_o
);

  caseu_pkg::req_t               req_d;
  caseu_pkg::req_t               req_q;
  logic                          req_valid_q;
  caseu_pkg::rsp_t               rsp_d;
  caseu_pkg::rsp_t               rsp_q;
  logic                          rsp_valid_q;
  caseu_pkg::wr_t                wr_raw;
  caseu_pkg::wr_t                wr;
  logic [3:0]                    flags_d;
  logic [3:0]                    flags_q;
  logic [caseu_pkg::DataW-1:0]   rn_data;
  logic [caseu_pkg::DataW-1:0]   rm_data;
  logic [caseu_pkg::DataW-1:0]   rs_data;
  logic [caseu_pkg::DataW-1:0]   pc_data;
  logic                          out_free;
  logic                          fire;
  logic                          accept;

  // An item executes when the result register can take its result; state
  // (registers and flags) commits in that same cycle, so the next item in
  // the input register always sees up to date operands.
  assign out_free    = !rsp_valid_q || res_o.ready;
  assign fire        = req_valid_q && out_free;
  assign exe_i.ready = !req_valid_q || out_free;
  assign accept      = exe_i.valid && exe_i.ready;

  always_comb begin
    req_d.func               = exe_i.func;
    req_d.cond               = exe_i.cond;
    req_d.opcode             = exe_i.opcode;
    req_d.imm_operand        = exe_i.imm_operand;
    req_d.set_flags          = exe_i.set_flags;
    req_d.reg_n              = exe_i.reg_n;
    req_d.reg_d              = exe_i.reg_d;
    req_d.operand2           = exe_i.operand2;
    req_d.accumulate_or_link = exe_i.accumulate_or_link;
    req_d.branch_offset      = exe_i.branch_offset;
    req_d.load_value         = exe_i.load_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (accept) begin
      req_valid_q <= 1'b1;
    end else if (fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

  caseu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rn_addr_i (req_q.reg_n),
    .rm_addr_i (req_q.operand2[3:0]),
    .rs_addr_i (req_q.operand2[11:8]),
    .rn_data_o (rn_data),
    .rm_data_o (rm_data),
    .rs_data_o (rs_data),
    .pc_data_o (pc_data),
    .wr_i      (wr)
  );

  caseu_exec u_exec (
    .req_i     (req_q),
    .flags_i   (flags_q),
    .rn_data_i (rn_data),
    .rm_data_i (rm_data),
    .rs_data_i (rs_data),
    .pc_data_i (pc_data),
    .rsp_o     (rsp_d),
    .wr_o      (wr_raw),
    .flags_o   (flags_d)
  );

  // writes only land when the item actually executes
  always_comb begin
    wr         = wr_raw;
    wr.en      = wr_raw.en && fire;
    wr.link_en = wr_raw.link_en && fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (fire) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign res_o.valid          = rsp_valid_q;
  assign res_o.executed       = rsp_q.executed;
  assign res_o.wrote_register = rsp_q.wrote_register;
  assign res_o.dest_reg       = rsp_q.dest_reg;
  assign res_o.result         = rsp_q.result;
  assign res_o.flag_n         = rsp_q.flag_n;
  assign res_o.flag_z         = rsp_q.flag_z;
  assign res_o.flag_c         = rsp_q.flag_c;
  assign res_o.flag_v         = rsp_q.flag_v;
  assign res_o.flush          = rsp_q.flush;

endmodule

@@ test/tb_cond_alu_shift_mult_branch_execute_unit.sv @@
`timescale 1ns / 1ps

module tb_cond_alu_shift_mult_branch_execute_unit;

  // ---------------------------------------------------------------------------
  // Run parameters
  // ---------------------------------------------------------------------------
  localparam int unsigned NumChunks   = 18;      // random instruction batches
  localparam int unsigned ChunkItems  = 100;     // items per batch
  localparam int unsigned CycleLimit  = 400000;  // hard stop, well above worst case
  localparam int unsigned DrainCycles = 8;       // pipe drain plus margin

  // Opcode outside the supported subset (BIC); must leave all state alone
  localparam logic [3:0] OpBic = 4'd14;

  localparam caseu_pkg::opcode_e AluOps [10] = '{
    caseu_pkg::OP_AND, caseu_pkg::OP_EOR, caseu_pkg::OP_SUB, caseu_pkg::OP_RSB,
    caseu_pkg::OP_ADD, caseu_pkg::OP_TST, caseu_pkg::OP_TEQ, caseu_pkg::OP_CMP,
    caseu_pkg::OP_ORR, caseu_pkg::OP_MOV
  };

  // Values that hit shifter corner cases when they end up as shift amounts
  // or operands: zero, all ones, sign boundaries, multiples of 32.
  localparam logic [31:0] EdgeVals [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'd32, 32'd64, 32'd96, 32'd256
  };

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  caseu_in_if  exe ();
  caseu_out_if res ();

  cond_alu_shift_mult_branch_execute_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exe_i  (exe),
    .res_o  (res)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  caseu_pkg::req_t pend_q[$];     // instructions waiting to be driven
  caseu_pkg::rsp_t exp_q[$];      // predicted results, oldest first
  logic [31:0]     arch_regs [caseu_pkg::NumRegs];
  nzcv_t           arch_flags;

  int unsigned idle_pct;      // chance per cycle of starting an idle burst
  int unsigned in_gap;
  int unsigned out_gap;
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned n_predicted;
  int unsigned n_checked;
  int unsigned n_exec;
  int unsigned n_flush;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  // ---------------------------------------------------------------------------
  // Architectural model of the execute stage
  // ---------------------------------------------------------------------------

  // Barrel shifter with ARM carry-out rules. Amount 0 passes the operand and
  // the incoming carry through untouched (no RRX here). Register-specified
  // amounts may reach 255, so the >= 32 cases matter.
  function automatic logic [31:0] barrel_shift(input logic [31:0] v, input logic [1:0] kind,
                                               input int unsigned amt, input logic cin,
                                               output logic cout);
    logic [31:0] r;
    int unsigned rot;
    if (amt == 0) begin
      cout = cin;
      return v;
    end
    case (kind)
      caseu_pkg::SH_LSL: begin
        if (amt < 32) begin
          cout = v[32-amt];
          r    = v << amt;
        end else begin
          cout = (amt == 32) ? v[0] : 1'b0;
          r    = '0;
        end
      end
      caseu_pkg::SH_LSR: begin
        if (amt < 32) begin
          cout = v[amt-1];
          r    = v >> amt;
        end else begin
          cout = (amt == 32) ? v[31] : 1'b0;
          r    = '0;
        end
      end
      caseu_pkg::SH_ASR: begin
        if (amt < 32) begin
          cout = v[amt-1];
          r    = $signed(v) >>> amt;
        end else begin
          // everything shifted out, sign fills the word
          cout = v[31];
          r    = {32{v[31]}};
        end
      end
      default: begin
        rot = amt % 32;
        if (rot == 0) begin
          // rotate by a whole multiple of 32: value kept, carry is bit 31
          cout = v[31];
          r    = v;
        end else begin
          r    = (v >> rot) | (v << (32 - rot));
          cout = r[31];
        end
      end
    endcase
    return r;
  endfunction

  // Condition check, grouped by the even code of each pair; odd codes are the
  // inverse of their even partner (AL/NV included).
  function automatic logic cond_holds(input logic [3:0] code);
    logic base;
    case ({code[3:1], 1'b0})
      caseu_pkg::COND_EQ: base = arch_flags.z;
      caseu_pkg::COND_CS: base = arch_flags.c;
      caseu_pkg::COND_MI: base = arch_flags.n;
      caseu_pkg::COND_VS: base = arch_flags.v;
      caseu_pkg::COND_HI: base = arch_flags.c && !arch_flags.z;
      caseu_pkg::COND_GE: base = (arch_flags.n == arch_flags.v);
      caseu_pkg::COND_GT: base = !arch_flags.z && (arch_flags.n == arch_flags.v);
      default:            base = 1'b1;
    endcase
    return base ^ code[0];
  endfunction

  // Executes one instruction against the architectural state and returns the
  // result the block should report for it.
  function automatic caseu_pkg::rsp_t execute_insn(input caseu_pkg::req_t q);
    caseu_pkg::rsp_t o;
    logic [31:0]     a;
    logic [31:0]     b;
    logic [31:0]     val;
    logic [31:0]     off;
    logic            sc;
    logic            c;
    logic            ok;
    int unsigned     amt;
    o = '0;
    if (cond_holds(q.cond)) begin
      case (q.func)
        caseu_pkg::FUNC_DP: begin
          a = arch_regs[q.reg_n];
          if (q.imm_operand) begin
            amt = {q.operand2[11:8], 1'b0};
            b = barrel_shift({24'd0, q.operand2[7:0]}, caseu_pkg::SH_ROR, amt,
                             arch_flags.c, sc);
          end else begin
            amt = q.operand2[4] ? arch_regs[q.operand2[11:8]][7:0] : q.operand2[11:7];
            b = barrel_shift(arch_regs[q.operand2[3:0]], q.operand2[6:5], amt,
                             arch_flags.c, sc);
          end
          c   = sc;
          ok  = 1'b1;
          val = '0;
          case (q.opcode)
            caseu_pkg::OP_AND, caseu_pkg::OP_TST: val = a & b;
            caseu_pkg::OP_EOR, caseu_pkg::OP_TEQ: val = a ^ b;
            caseu_pkg::OP_SUB, caseu_pkg::OP_CMP: begin
              val = a - b;
              c   = (a >= b);   // carry = no borrow
            end
            caseu_pkg::OP_RSB: begin
              val = b - a;
              c   = (b >= a);
            end
            caseu_pkg::OP_ADD: {c, val} = {1'b0, a} + {1'b0, b};
            caseu_pkg::OP_ORR: val = a | b;
            caseu_pkg::OP_MOV: val = b;
            default:           ok = 1'b0;
          endcase
          if (ok) begin
            o.executed = 1'b1;
            o.result   = val;
            if (!(q.opcode inside {caseu_pkg::OP_TST, caseu_pkg::OP_TEQ,
                                   caseu_pkg::OP_CMP})) begin
              arch_regs[q.reg_d] = val;
              o.wrote_register   = 1'b1;
              o.dest_reg         = q.reg_d;
            end
            if (q.set_flags) begin
              arch_flags.n = val[31];
              arch_flags.z = (val == '0);
              arch_flags.c = c;
            end
          end
        end
        caseu_pkg::FUNC_MUL: begin
          val = arch_regs[q.operand2[3:0]] * arch_regs[q.operand2[11:8]];
          if (q.accumulate_or_link) val += arch_regs[q.reg_n];
          arch_regs[q.reg_d] = val;
          o.executed         = 1'b1;
          o.wrote_register   = 1'b1;
          o.dest_reg         = q.reg_d;
          o.result           = val;
          if (q.set_flags) begin
            arch_flags.n = val[31];
            arch_flags.z = (val == '0);
          end
        end
        caseu_pkg::FUNC_BR: begin
          off = {{6{q.branch_offset[23]}}, q.branch_offset, 2'b00};
          if (q.accumulate_or_link) begin
            arch_regs[caseu_pkg::REG_LR] = arch_regs[caseu_pkg::REG_PC] - 32'd4;
          end
          arch_regs[caseu_pkg::REG_PC] = arch_regs[caseu_pkg::REG_PC] + off;
          o.executed        = 1'b1;
          o.wrote_register  = 1'b1;
          o.dest_reg        = caseu_pkg::REG_PC;
          o.result          = arch_regs[caseu_pkg::REG_PC];
        end
        default: begin
          // register load
          arch_regs[q.reg_d] = q.load_value;
          o.executed         = 1'b1;
          o.wrote_register   = 1'b1;
          o.dest_reg         = q.reg_d;
          o.result           = q.load_value;
        end
      endcase
    end
    o.flag_n = arch_flags.n;
    o.flag_z = arch_flags.z;
    o.flag_c = arch_flags.c;
    o.flag_v = arch_flags.v;
    o.flush  = o.wrote_register && (o.dest_reg == caseu_pkg::REG_PC);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Instruction builders for the directed part (always-execute, but branches take a condition)
  // ---------------------------------------------------------------------------
  function automatic caseu_pkg::req_t ld_insn(input logic [3:0] rd, input logic [31:0] val);
    caseu_pkg::req_t q;
    q            = '0;
    q.func       = caseu_pkg::FUNC_LDR;
    q.cond       = caseu_pkg::COND_AL;
    q.reg_d      = rd;
    q.load_value = val;
    return q;
  endfunction

  function automatic caseu_pkg::req_t dp_insn(input logic [3:0] opc, input logic imm,
                                              input logic sf, input logic [3:0] rn,
                                              input logic [3:0] rd, input logic [11:0] op2);
    caseu_pkg::req_t q;
    q             = '0;
    q.func        = caseu_pkg::FUNC_DP;
    q.cond        = caseu_pkg::COND_AL;
    q.opcode      = opc;
    q.imm_operand = imm;
    q.set_flags   = sf;
    q.reg_n       = rn;
    q.reg_d       = rd;
    q.operand2    = op2;
    return q;
  endfunction

  function automatic caseu_pkg::req_t mul_insn(input logic sf, input logic acc,
                                               input logic [3:0] rn, input logic [3:0] rd,
                                               input logic [3:0] rm, input logic [3:0] rs);
    caseu_pkg::req_t q;
    q                    = '0;
    q.func               = caseu_pkg::FUNC_MUL;
    q.cond               = caseu_pkg::COND_AL;
    q.set_flags          = sf;
    q.accumulate_or_link = acc;
    q.reg_n              = rn;
    q.reg_d              = rd;
    q.operand2           = {rs, 4'd0, rm};
    return q;
  endfunction

  function automatic caseu_pkg::req_t br_insn(input logic [3:0] code, input logic link,
                                              input logic [23:0] off);
    caseu_pkg::req_t q;
    q                    = '0;
    q.func               = caseu_pkg::FUNC_BR;
    q.cond               = code;
    q.accumulate_or_link = link;
    q.branch_offset      = off;
    return q;
  endfunction

  // Random instruction. Half data processing, mostly with supported opcodes and an
  // always condition, so that register and flag state keeps evolving; every
  // field is random underneath, unused ones included.
  function automatic caseu_pkg::req_t rand_insn();
    caseu_pkg::req_t q;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      q.func = caseu_pkg::FUNC_DP;
    else if (pick < 62) q.func = caseu_pkg::FUNC_MUL;
    else if (pick < 70) q.func = caseu_pkg::FUNC_BR;
    else                q.func = caseu_pkg::FUNC_LDR;
    if ($urandom_range(0, 99) < 65) q.cond = caseu_pkg::COND_AL;
    else                            q.cond = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 88) q.opcode = AluOps[$urandom_range(0, 9)];
    else                            q.opcode = 4'($urandom_range(0, 15));
    q.imm_operand        = 1'($urandom_range(0, 1));
    q.set_flags          = 1'($urandom_range(0, 1));
    q.reg_n              = 4'($urandom_range(0, 15));
    q.reg_d              = 4'($urandom_range(0, 15));
    q.operand2           = 12'($urandom_range(0, 4095));
    q.accumulate_or_link = 1'($urandom_range(0, 1));
    q.branch_offset      = 24'($urandom_range(0, 24'hFF_FFFF));
    // small and edge values make register shifts land on 0, 32, > 32
    case ($urandom_range(0, 4))
      0:       q.load_value = $urandom_range(0, 40);
      1:       q.load_value = EdgeVals[$urandom_range(0, 7)];
      default: q.load_value = $urandom;
    endcase
    return q;
  endfunction

  task automatic queue_insn(input caseu_pkg::req_t q);
    pend_q.push_back(q);
    n_queued++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("[%0t] result #%0d: %s is %h, expected %h", $time, n_checked, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued instructions on exe, predicts each one on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exe.valid              <= 1'b0;
      exe.func               <= '0;
      exe.cond               <= '0;
      exe.opcode             <= '0;
      exe.imm_operand        <= 1'b0;
      exe.set_flags          <= 1'b0;
      exe.reg_n              <= '0;
      exe.reg_d              <= '0;
      exe.operand2           <= '0;
      exe.accumulate_or_link <= 1'b0;
      exe.branch_offset      <= '0;
      exe.load_value         <= '0;
      in_gap = 0;
    end else begin : drv
      caseu_pkg::req_t taken;
      caseu_pkg::req_t nxt;
      caseu_pkg::rsp_t want;
      if (exe.valid && exe.ready) begin
        // payload still holds the item that was just accepted
        taken.func               = exe.func;
        taken.cond               = exe.cond;
        taken.opcode             = exe.opcode;
        taken.imm_operand        = exe.imm_operand;
        taken.set_flags          = exe.set_flags;
        taken.reg_n              = exe.reg_n;
        taken.reg_d              = exe.reg_d;
        taken.operand2           = exe.operand2;
        taken.accumulate_or_link = exe.accumulate_or_link;
        taken.branch_offset      = exe.branch_offset;
        taken.load_value         = exe.load_value;
        want = execute_insn(taken);
        exp_q.push_back(want);
        n_predicted++;
        n_taken++;
        if (want.executed) n_exec++;
        if (want.flush)    n_flush++;
      end
      // slot is free: either idle for a burst or present the next item
      if (!exe.valid || exe.ready) begin
        if (in_gap == 0 && $urandom_range(0, 99) < idle_pct) in_gap = $urandom_range(1, 19);
        if (in_gap > 0) begin
          in_gap--;
          exe.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          exe.func               <= nxt.func;
          exe.cond               <= nxt.cond;
          exe.opcode             <= nxt.opcode;
          exe.imm_operand        <= nxt.imm_operand;
          exe.set_flags          <= nxt.set_flags;
          exe.reg_n              <= nxt.reg_n;
          exe.reg_d              <= nxt.reg_d;
          exe.operand2           <= nxt.operand2;
          exe.accumulate_or_link <= nxt.accumulate_or_link;
          exe.branch_offset      <= nxt.branch_offset;
          exe.load_value         <= nxt.load_value;
          exe.valid              <= 1'b1;
        end else begin
          exe.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls res in random bursts, checks every result in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      out_gap = 0;
    end else begin : mon
      caseu_pkg::rsp_t got;
      caseu_pkg::rsp_t want;
      if (res.valid && res.ready) begin
        got.executed       = res.executed;
        got.wrote_register = res.wrote_register;
        got.dest_reg       = res.dest_reg;
        got.result         = res.result;
        got.flag_n         = res.flag_n;
        got.flag_z         = res.flag_z;
        got.flag_c         = res.flag_c;
        got.flag_v         = res.flag_v;
        got.flush          = res.flush;
        if (exp_q.size() == 0) begin
          report_mismatch("unexpected result, value", got.result, '0);
        end else begin
          want = exp_q.pop_front();
          n_checked++;
          if (got.executed !== want.executed)
            report_mismatch("executed", 32'(got.executed), 32'(want.executed));
          if (got.wrote_register !== want.wrote_register)
            report_mismatch("wrote_register", 32'(got.wrote_register),
                            32'(want.wrote_register));
          if (got.dest_reg !== want.dest_reg)
            report_mismatch("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
          if (got.result !== want.result)
            report_mismatch("result", got.result, want.result);
          if (got.flag_n !== want.flag_n)
            report_mismatch("flag_n", 32'(got.flag_n), 32'(want.flag_n));
          if (got.flag_z !== want.flag_z)
            report_mismatch("flag_z", 32'(got.flag_z), 32'(want.flag_z));
          if (got.flag_c !== want.flag_c)
            report_mismatch("flag_c", 32'(got.flag_c), 32'(want.flag_c));
          if (got.flag_v !== want.flag_v)
            report_mismatch("flag_v", 32'(got.flag_v), 32'(want.flag_v));
          if (got.flush !== want.flush)
            report_mismatch("flush", 32'(got.flush), 32'(want.flush));
        end
      end
      if (out_gap == 0 && $urandom_range(0, 99) < idle_pct) out_gap = $urandom_range(1, 19);
      if (out_gap > 0) begin
        out_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d results seen",
               cycle_cnt, n_checked, n_queued);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stim
    caseu_pkg::req_t q;
    rst_ni = 1'b0;
    idle_pct    = 20;
    n_queued    = 0;
    n_taken     = 0;
    n_predicted = 0;
    n_checked   = 0;
    n_exec      = 0;
    n_flush     = 0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    arch_flags  = '0;
    for (int i = 0; i < caseu_pkg::NumRegs; i++) arch_regs[i] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed: operand setup ---
    queue_insn(ld_insn(4'd1, 32'hFFFF_FFFF));
    queue_insn(ld_insn(4'd2, 32'h8000_0000));
    queue_insn(ld_insn(4'd3, 32'd1));
    queue_insn(ld_insn(4'd4, 32'd32));
    queue_insn(ld_insn(4'd5, 32'd40));
    queue_insn(ld_insn(4'd6, 32'd64));
    // --- each ALU op, both operand forms ---
    // LSL #0: operand as is, carry from old C
    queue_insn(dp_insn(caseu_pkg::OP_AND, 1'b0, 1'b1, 4'd1, 4'd7,
                       {5'd0, caseu_pkg::SH_LSL, 1'b0, 4'd2}));
    // imm 0xFF ror 8: carry taken from bit 31 of the rotated value
    queue_insn(dp_insn(caseu_pkg::OP_EOR, 1'b1, 1'b1, 4'd0, 4'd8, {4'd4, 8'hFF}));
    // 1 - 0xFFFFFFFF borrows, C clear
    queue_insn(dp_insn(caseu_pkg::OP_SUB, 1'b0, 1'b1, 4'd3, 4'd9,
                       {5'd0, caseu_pkg::SH_LSL, 1'b0, 4'd1}));
    queue_insn(dp_insn(caseu_pkg::OP_RSB, 1'b0, 1'b1, 4'd0, 4'd10,
                       {5'd1, caseu_pkg::SH_LSR, 1'b0, 4'd3}));
    // wraps to zero: Z and C set
    queue_insn(dp_insn(caseu_pkg::OP_ADD, 1'b0, 1'b1, 4'd1, 4'd11,
                       {5'd0, caseu_pkg::SH_LSL, 1'b0, 4'd3}));
    // Z is set now, so NE fails and nothing happens
    q = dp_insn(caseu_pkg::OP_TST, 1'b1, 1'b1, 4'd1, 4'd0, {4'd0, 8'h80});
    q.cond = caseu_pkg::COND_NE;
    queue_insn(q);
    queue_insn(dp_insn(caseu_pkg::OP_TST, 1'b1, 1'b1, 4'd1, 4'd0, {4'd0, 8'h80}));
    queue_insn(dp_insn(caseu_pkg::OP_TEQ, 1'b0, 1'b1, 4'd2, 4'd0,
                       {5'd31, caseu_pkg::SH_ASR, 1'b0, 4'd2}));
    // ROR with an immediate amount of zero keeps the operand (no RRX)
    queue_insn(dp_insn(caseu_pkg::OP_CMP, 1'b0, 1'b1, 4'd3, 4'd0,
                       {5'd0, caseu_pkg::SH_ROR, 1'b0, 4'd2}));
    // register shifts: LSR by 32, ASR by 40, ROR by 64, LSL by 32 and 40
    queue_insn(dp_insn(caseu_pkg::OP_ORR, 1'b0, 1'b1, 4'd0, 4'd12,
                       {4'd4, 1'b0, caseu_pkg::SH_LSR, 1'b1, 4'd2}));
    queue_insn(dp_insn(caseu_pkg::OP_MOV, 1'b0, 1'b1, 4'd0, 4'd13,
                       {4'd5, 1'b0, caseu_pkg::SH_ASR, 1'b1, 4'd2}));
    queue_insn(dp_insn(caseu_pkg::OP_MOV, 1'b0, 1'b1, 4'd0, 4'd13,
                       {4'd6, 1'b0, caseu_pkg::SH_ROR, 1'b1, 4'd2}));
    queue_insn(dp_insn(caseu_pkg::OP_MOV, 1'b0, 1'b1, 4'd0, 4'd13,
                       {4'd4, 1'b0, caseu_pkg::SH_LSL, 1'b1, 4'd3}));
    queue_insn(dp_insn(caseu_pkg::OP_MOV, 1'b0, 1'b1, 4'd0, 4'd13,
                       {4'd5, 1'b0, caseu_pkg::SH_LSL, 1'b1, 4'd3}));
    // unsupported opcode: no effect at all
    queue_insn(dp_insn(OpBic, 1'b0, 1'b1, 4'd1, 4'd1,
                       {5'd0, caseu_pkg::SH_LSL, 1'b0, 4'd2}));
    // multiply-accumulate, then a zero product to set Z
    queue_insn(mul_insn(1'b1, 1'b1, 4'd3, 4'd8, 4'd1, 4'd1));
    queue_insn(mul_insn(1'b1, 1'b0, 4'd0, 4'd9, 4'd0, 4'd1));
    // branch and link backwards, never-branch, forward max offset
    queue_insn(br_insn(caseu_pkg::COND_AL, 1'b1, 24'hFF_FFFF));
    queue_insn(br_insn(caseu_pkg::COND_NV, 1'b1, 24'h7F_FFFF));
    queue_insn(br_insn(caseu_pkg::COND_AL, 1'b0, 24'h7F_FFFF));
    // PC written by MOV and by a load: both flush
    queue_insn(dp_insn(caseu_pkg::OP_MOV, 1'b1, 1'b0, 4'd0, caseu_pkg::REG_PC,
                       {4'd0, 8'h40}));
    queue_insn(ld_insn(caseu_pkg::REG_PC, 32'h1234_5678));
    wait (pend_q.size() == 0);

    // --- random batches, each with its own idling level; last one has none ---
    for (int k = 0; k < NumChunks; k++) begin
      if (k == NumChunks - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 5;
          default: idle_pct = 25;
        endcase
      end
      for (int i = 0; i < ChunkItems; i++) queue_insn(rand_insn());
      wait (pend_q.size() == 0);
    end

    // everything accepted, everything answered, then a little settle time
    wait (n_taken == n_queued);
    wait (n_checked == n_predicted);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d instructions: %0d executed, %0d pipeline flushes.",
             n_taken, n_exec, n_flush);
    $display("Compared %0d results field by field, %0d field mismatches.",
             n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
